### rtl/mstdrr_pkg.sv
// Shared constants, state type and status struct of the minimal-standard random unit.
package mstdrr_pkg;

   localparam int unsigned STATE_W    = 31;
   localparam int unsigned RANGE_W    = 32;
   localparam int unsigned MULT_W     = 16;
   localparam int unsigned MULT_CNT_W = $clog2(MULT_W + 1);
   localparam int unsigned DIV_CNT_W  = $clog2(STATE_W + 1);
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [MULT_W-1:0]  MINSTD_MULT    = 16'hbc8f;
   localparam logic [STATE_W-1:0] MINSTD_DEFAULT = 31'h075bd924;
   localparam logic [STATE_W-1:0] MINSTD_MODULUS = 31'h7fffffff;

   localparam logic REG_SEED_IDX = 1'b0;

   localparam logic ACTION_DRAW    = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_SUM
   } ctrl_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

### rtl/mstdrr_channels.sv
// Valid/ready channel interfaces for the request and response items.
interface mstdrr_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [mstdrr_pkg::RANGE_W-1:0]    range_low;
   logic [mstdrr_pkg::RANGE_W-1:0]    range_high;

   modport source (output valid, action, range_low, range_high, input ready);
   modport sink (input valid, action, range_low, range_high, output ready);
endinterface

interface mstdrr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mstdrr_pkg::STATE_W-1:0]    raw_value;
   logic [mstdrr_pkg::RANGE_W-1:0]    ranged_value;

   modport source (output valid, raw_value, ranged_value, input ready);
   modport sink (input valid, raw_value, ranged_value, output ready);
endinterface

### rtl/mstdrr_lehmer.sv
// Bit-serial multiplier modulo 2^31-1 that advances the generator state.
module mstdrr_lehmer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mstdrr_pkg::STATE_W-1:0]   value,
   output mstdrr_pkg::unit_status_type      status,
   output logic [mstdrr_pkg::STATE_W-1:0]   result
);

   logic [mstdrr_pkg::STATE_W-1:0]    acc_ff, acc_in;
   logic [mstdrr_pkg::STATE_W-1:0]    val_ff, val_in;
   logic [mstdrr_pkg::MULT_W-1:0]     mult_ff, mult_in;
   logic [mstdrr_pkg::MULT_CNT_W-1:0] count_ff, count_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mstdrr_pkg::STATE_W-1:0]    rot;
   logic [mstdrr_pkg::STATE_W:0]      sum;
   logic [mstdrr_pkg::STATE_W-1:0]    fold;

   // Doubling modulo 2^31-1 is a rotation; addition folds its carry back in.
   always_comb begin
      rot  = {acc_ff[mstdrr_pkg::STATE_W-2:0], acc_ff[mstdrr_pkg::STATE_W-1]};
      sum  = {1'b0, rot} + {1'b0, val_ff};
      fold = sum[mstdrr_pkg::STATE_W-1:0]
             + {{(mstdrr_pkg::STATE_W-1){1'b0}}, sum[mstdrr_pkg::STATE_W]};

      acc_in   = acc_ff;
      val_in   = val_ff;
      mult_in  = mult_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         acc_in   = '0;
         val_in   = value;
         mult_in  = mstdrr_pkg::MINSTD_MULT;
         count_in = mstdrr_pkg::MULT_CNT_W'(mstdrr_pkg::MULT_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = mult_ff[mstdrr_pkg::MULT_W-1] ? fold : rot;
         mult_in  = {mult_ff[mstdrr_pkg::MULT_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == mstdrr_pkg::MULT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      val_ff  <= val_in;
      mult_ff <= mult_in;
   end

   // Both zero and the all-ones code stand for a zero residue.
   assign result = (acc_ff == '0 || acc_ff == mstdrr_pkg::MINSTD_MODULUS) ?
                   mstdrr_pkg::MINSTD_DEFAULT : acc_ff;

   assign status = {busy_ff, done_ff};

endmodule

### rtl/mstdrr_divider.sv
// Restoring bit-serial remainder of the raw value by the range span.
module mstdrr_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mstdrr_pkg::STATE_W-1:0]   dividend,
   input  logic [mstdrr_pkg::RANGE_W-1:0]   divisor,
   output mstdrr_pkg::unit_status_type      status,
   output logic [mstdrr_pkg::RANGE_W-1:0]   remainder
);

   logic [mstdrr_pkg::RANGE_W-1:0]   rem_ff, rem_in;
   logic [mstdrr_pkg::STATE_W-1:0]   shift_ff, shift_in;
   logic [mstdrr_pkg::RANGE_W-1:0]   div_ff, div_in;
   logic [mstdrr_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [mstdrr_pkg::RANGE_W:0]     trial;
   logic [mstdrr_pkg::RANGE_W+1:0]   diff;

   always_comb begin
      trial = {rem_ff, shift_ff[mstdrr_pkg::STATE_W-1]};
      diff  = {1'b0, trial} - {2'b00, div_ff};

      rem_in   = rem_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         rem_in   = '0;
         shift_in = dividend;
         div_in   = divisor;
         count_in = mstdrr_pkg::DIV_CNT_W'(mstdrr_pkg::STATE_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = diff[mstdrr_pkg::RANGE_W+1] ? trial[mstdrr_pkg::RANGE_W-1:0]
                                                : diff[mstdrr_pkg::RANGE_W-1:0];
         shift_in = {shift_ff[mstdrr_pkg::STATE_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == mstdrr_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
   end

   assign remainder = rem_ff;
   assign status    = {busy_ff, done_ff};

endmodule

### rtl/minstd_random_with_range_unit.sv
// Top level of the minimal-standard random unit with ranged result.
//
// The request channel carries an action bit and a range. A draw item advances
// the 31-bit Lehmer state (multiplier 48271 modulo 2^31-1) and yields one
// response item with the new state and range_low plus the state modulo the
// span range_high - range_low + 1, wrapping in 32 bits; a span that wraps to
// zero adds the state itself. A restart item reloads the state from the seed
// register and yields no response item.
// A draw runs a 16-step bit-serial modular multiply and then a 31-step
// bit-serial remainder loop, which is skipped when the span wraps to zero;
// the request channel is ready only while idle, so the next item is taken
// only after the last one has left its summing step.
// The response sits in an output register; if the receiver stalls, a new item
// is still accepted and computed, and it waits in its last step until the
// output register is taken.
// Reset empties the block, sets the seed register and the state to 123459876.
// The seed is written through the APB port at byte address 0.
module minstd_random_with_range_unit (
   input  logic                                clock,
   input  logic                                reset,
   mstdrr_req_if.sink                          req_bus,
   mstdrr_rsp_if.source                        rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mstdrr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mstdrr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mstdrr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   mstdrr_pkg::ctrl_state_type         state_ff, state_in;
   logic [mstdrr_pkg::STATE_W-1:0]     seed_ff, seed_in;
   logic [mstdrr_pkg::STATE_W-1:0]     cur_ff, cur_in;
   logic [mstdrr_pkg::RANGE_W-1:0]     lo_ff, lo_in;
   logic [mstdrr_pkg::RANGE_W-1:0]     span_ff, span_in;
   logic                               bypass_ff, bypass_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mstdrr_pkg::STATE_W-1:0]     rsp_raw_ff, rsp_raw_in;
   logic [mstdrr_pkg::RANGE_W-1:0]     rsp_ranged_ff, rsp_ranged_in;

   logic                               req_accept;
   logic                               csr_write;
   logic                               lm_start;
   logic                               dv_start;
   mstdrr_pkg::unit_status_type        lm_status;
   mstdrr_pkg::unit_status_type        dv_status;
   logic [mstdrr_pkg::STATE_W-1:0]     lm_result;
   logic [mstdrr_pkg::RANGE_W-1:0]     dv_rem;
   logic [mstdrr_pkg::STATE_W-1:0]     eff_seed;
   logic [mstdrr_pkg::RANGE_W-1:0]     span_calc;
   logic [mstdrr_pkg::RANGE_W-1:0]     addend;

   mstdrr_lehmer u_lehmer (
      .clock  (clock),
      .reset  (reset),
      .start  (lm_start),
      .value  (cur_ff),
      .status (lm_status),
      .result (lm_result)
   );

   mstdrr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (dv_start),
      .dividend  (lm_result),
      .divisor   (span_ff),
      .status    (dv_status),
      .remainder (dv_rem)
   );

   assign req_bus.ready = (state_ff == mstdrr_pkg::ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == mstdrr_pkg::REG_SEED_IDX);
   assign csr_prdata = (csr_paddr[2] == mstdrr_pkg::REG_SEED_IDX) ?
                       {1'b0, seed_ff} : '0;

   assign eff_seed  = (seed_ff != '0) ? seed_ff : mstdrr_pkg::MINSTD_DEFAULT;
   assign span_calc = req_bus.range_high - req_bus.range_low + 1'b1;
   assign addend    = bypass_ff ? {1'b0, cur_ff} : dv_rem;

   always_comb begin
      state_in      = state_ff;
      seed_in       = csr_write ? csr_pwdata[mstdrr_pkg::STATE_W-1:0] : seed_ff;
      cur_in        = cur_ff;
      lo_in         = lo_ff;
      span_in       = span_ff;
      bypass_in     = bypass_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_raw_in    = rsp_raw_ff;
      rsp_ranged_in = rsp_ranged_ff;
      lm_start      = 1'b0;
      dv_start      = 1'b0;

      case (state_ff)
         mstdrr_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.action == mstdrr_pkg::ACTION_RESTART) begin
                  cur_in = eff_seed;
               end else begin
                  lo_in     = req_bus.range_low;
                  span_in   = span_calc;
                  bypass_in = (span_calc == '0);
                  lm_start  = 1'b1;
                  state_in  = mstdrr_pkg::ST_MULT;
               end
            end
         end
         mstdrr_pkg::ST_MULT: begin
            if (lm_status.done) begin
               cur_in = lm_result;
               if (bypass_ff) begin
                  state_in = mstdrr_pkg::ST_SUM;
               end else begin
                  dv_start = 1'b1;
                  state_in = mstdrr_pkg::ST_DIV;
               end
            end
         end
         mstdrr_pkg::ST_DIV: begin
            if (dv_status.done) begin
               state_in = mstdrr_pkg::ST_SUM;
            end
         end
         mstdrr_pkg::ST_SUM: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = cur_ff;
               rsp_ranged_in = lo_ff + addend;
               state_in      = mstdrr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mstdrr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mstdrr_pkg::ST_IDLE;
         seed_ff      <= mstdrr_pkg::MINSTD_DEFAULT;
         cur_ff       <= mstdrr_pkg::MINSTD_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      span_ff       <= span_in;
      bypass_ff     <= bypass_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.raw_value    = rsp_raw_ff;
   assign rsp_bus.ranged_value = rsp_ranged_ff;

   // The multiplier reports completion only while the controller waits for it.
   a_lm_done_in_mult: assert property (@(posedge clock) disable iff (reset)
      lm_status.done |-> state_ff == mstdrr_pkg::ST_MULT)
      else $error("multiplier finished outside the multiply phase");

   a_dv_done_in_div: assert property (@(posedge clock) disable iff (reset)
      dv_status.done |-> state_ff == mstdrr_pkg::ST_DIV)
      else $error("divider finished outside the remainder phase");

   // The multiplier and the divider never run at the same time.
   a_one_engine: assert property (@(posedge clock) disable iff (reset)
      !(lm_status.busy && dv_status.busy))
      else $error("multiplier and divider busy together");

   // A new response is loaded only from the final summing step.
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_bus.ready) && !$past(reset))
      |-> $past(state_ff) == mstdrr_pkg::ST_SUM)
      else $error("response loaded outside the summing step");

   // The generator never hands out zero or the modulus as a state.
   a_raw_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_raw_ff != '0 && rsp_raw_ff != mstdrr_pkg::MINSTD_MODULUS))
      else $error("raw value out of the generator range");

endmodule

### tb/tb_minstd_random_with_range_unit.sv
// Self-checking testbench for the minimal-standard random unit with ranged result.
module tb_minstd_random_with_range_unit;

   localparam int     CLK_PERIOD     = 20;
   localparam int     RESET_CYCLES   = 3;
   localparam int     SETTLE_CYCLES  = 60;
   localparam int     RANDOM_ITEMS   = 1850;
   localparam int     TIMEOUT_CYCLES = 1000000;
   localparam longint SCHRAGE_Q      = 64'hadc8;
   localparam longint SCHRAGE_R      = 64'h0d47;
   localparam longint LEHMER_MOD     = longint'(mstdrr_pkg::MINSTD_MODULUS);
   localparam int     UNMAPPED_IDX   = 1;

   localparam logic [mstdrr_pkg::CSR_ADDR_W-1:0] SEED_ADDR =
      mstdrr_pkg::CSR_ADDR_W'(int'(mstdrr_pkg::REG_SEED_IDX) * 4);
   localparam logic [mstdrr_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      mstdrr_pkg::CSR_ADDR_W'(UNMAPPED_IDX * 4);

   typedef struct packed {
      logic                           action;
      logic [mstdrr_pkg::RANGE_W-1:0] range_low;
      logic [mstdrr_pkg::RANGE_W-1:0] range_high;
   } range_req_type;

   typedef struct packed {
      logic [mstdrr_pkg::STATE_W-1:0] raw_value;
      logic [mstdrr_pkg::RANGE_W-1:0] ranged_value;
   } draw_result_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [mstdrr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mstdrr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mstdrr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   mstdrr_req_if req_if ();
   mstdrr_rsp_if rsp_if ();

   minstd_random_with_range_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   range_req_type                  pending_reqs[$];
   draw_result_type                expected_draws[$];
   logic [mstdrr_pkg::STATE_W-1:0] lehmer_state;
   logic [mstdrr_pkg::STATE_W-1:0] seed_shadow;
   logic                           req_taken;
   logic                           idle_on;
   int unsigned                    req_gap_left;
   int unsigned                    rsp_gap_left;
   int unsigned                    error_count;

   function automatic logic [mstdrr_pkg::STATE_W-1:0] lehmer_next(
      input logic [mstdrr_pkg::STATE_W-1:0] cur);
      longint quot;
      longint rem;
      longint t;
      quot = longint'(cur) / SCHRAGE_Q;
      rem  = longint'(cur) % SCHRAGE_Q;
      t    = longint'(mstdrr_pkg::MINSTD_MULT) * rem - SCHRAGE_R * quot;
      if (t < 0) begin
         t = t + LEHMER_MOD;
      end
      if (t >= LEHMER_MOD) begin
         t = t - LEHMER_MOD;
      end
      if (t == 0) begin
         t = longint'(mstdrr_pkg::MINSTD_DEFAULT);
      end
      return t[mstdrr_pkg::STATE_W-1:0];
   endfunction

   function automatic logic [mstdrr_pkg::RANGE_W-1:0] range_fold(
      input logic [mstdrr_pkg::STATE_W-1:0] raw,
      input logic [mstdrr_pkg::RANGE_W-1:0] lo,
      input logic [mstdrr_pkg::RANGE_W-1:0] hi);
      logic [mstdrr_pkg::RANGE_W-1:0] span;
      logic [mstdrr_pkg::RANGE_W-1:0] raw_ext;
      span    = hi - lo + 32'd1;
      raw_ext = mstdrr_pkg::RANGE_W'(raw);
      if (span == '0) begin
         return lo + raw_ext;
      end
      return lo + (raw_ext % span);
   endfunction

   task automatic queue_req(input logic action, input logic [mstdrr_pkg::RANGE_W-1:0] lo,
                            input logic [mstdrr_pkg::RANGE_W-1:0] hi);
      range_req_type r;
      r.action     = action;
      r.range_low  = lo;
      r.range_high = hi;
      pending_reqs.push_back(r);
   endtask

   task automatic settle_unit();
      while (pending_reqs.size() != 0 || req_if.valid || expected_draws.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [mstdrr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [mstdrr_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (addr[2] == mstdrr_pkg::REG_SEED_IDX) begin
         seed_shadow = data[mstdrr_pkg::STATE_W-1:0];
      end
      @(negedge clock);
      if (addr[2] == mstdrr_pkg::REG_SEED_IDX && csr_prdata !== {1'b0, seed_shadow}) begin
         $error("seed: expected 0x%08h, actual 0x%08h", {1'b0, seed_shadow}, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic queue_random_req();
      logic [mstdrr_pkg::RANGE_W-1:0] lo;
      logic [mstdrr_pkg::RANGE_W-1:0] hi;
      lo = $urandom;
      case ($urandom_range(0, 7))
         0: begin
            hi = $urandom;
         end
         1: begin
            hi = lo + $urandom_range(0, 15);
         end
         2: begin
            hi = lo - 32'd1;
         end
         3: begin
            lo = '0;
            hi = '1;
         end
         4: begin
            hi = lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
         end
         5: begin
            lo = $urandom_range(0, 1000);
            hi = lo + $urandom_range(0, 1000);
         end
         6: begin
            hi = lo + $urandom_range(0, 32'h7fffffff);
         end
         default: begin
            hi = lo;
         end
      endcase
      queue_req(($urandom_range(0, 19) == 0) ? mstdrr_pkg::ACTION_RESTART
                                             : mstdrr_pkg::ACTION_DRAW, lo, hi);
   endtask

   always begin
      #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(negedge clock) begin
      range_req_type next_req;
      if (!reset && (!req_if.valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap_left != 0) begin
            req_gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
            req_gap_left = $urandom_range(0, 5);
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            req_if.valid      <= 1'b1;
            req_if.action     <= next_req.action;
            req_if.range_low  <= next_req.range_low;
            req_if.range_high <= next_req.range_high;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_gap_left != 0) begin
         rsp_gap_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_gap_left = $urandom_range(0, 5);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      draw_result_type want;
      draw_result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            if (req_if.action == mstdrr_pkg::ACTION_RESTART) begin
               lehmer_state = (seed_shadow != '0) ? seed_shadow
                                                  : mstdrr_pkg::MINSTD_DEFAULT;
            end else begin
               lehmer_state       = lehmer_next(lehmer_state);
               want.raw_value     = lehmer_state;
               want.ranged_value  = range_fold(lehmer_state, req_if.range_low,
                                               req_if.range_high);
               expected_draws.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.raw_value    = rsp_if.raw_value;
            got.ranged_value = rsp_if.ranged_value;
            if (expected_draws.size() == 0) begin
               $error("unexpected result item: raw_value 0x%08h ranged_value 0x%08h",
                      got.raw_value, got.ranged_value);
               error_count++;
            end else begin
               want = expected_draws.pop_front();
               if (got.raw_value !== want.raw_value) begin
                  $error("raw_value: expected 0x%08h, actual 0x%08h",
                         want.raw_value, got.raw_value);
                  error_count++;
               end
               if (got.ranged_value !== want.ranged_value) begin
                  $error("ranged_value: expected 0x%08h, actual 0x%08h",
                         want.ranged_value, got.ranged_value);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int unsigned random_count;
      int unsigned batch;
      clock             = 1'b0;
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_if.valid      = 1'b0;
      req_if.action     = mstdrr_pkg::ACTION_DRAW;
      req_if.range_low  = '0;
      req_if.range_high = '0;
      rsp_if.ready      = 1'b1;
      req_taken         = 1'b0;
      idle_on           = 1'b1;
      req_gap_left      = 0;
      rsp_gap_left      = 0;
      error_count       = 0;
      lehmer_state      = mstdrr_pkg::MINSTD_DEFAULT;
      seed_shadow       = mstdrr_pkg::MINSTD_DEFAULT;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h8000_0000, 32'h7fff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0064, 32'h0000_000a);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'h0000_0006);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'hffff_ffff, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_RESTART, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'h0000_ffff);
      settle_unit();
      write_csr(SEED_ADDR, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_RESTART, 32'h0000_0000, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'h0000_0063);
      settle_unit();
      write_csr(SEED_ADDR, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_RESTART, 32'h0000_0000, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h1234_5678, 32'h1234_5678);
      settle_unit();
      write_csr(SEED_ADDR, 32'h0000_0001);
      queue_req(mstdrr_pkg::ACTION_RESTART, 32'h0000_0000, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'hffff_ffff);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0010, 32'h0000_0001);
      settle_unit();
      write_csr(UNMAPPED_ADDR, 32'h1234_5678);
      queue_req(mstdrr_pkg::ACTION_RESTART, 32'h0000_0000, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'hffff_ffff);
      settle_unit();
      write_csr(SEED_ADDR, 32'h7fff_fffe);
      queue_req(mstdrr_pkg::ACTION_RESTART, 32'h0000_0000, 32'h0000_0000);
      queue_req(mstdrr_pkg::ACTION_DRAW, 32'h0000_0000, 32'hffff_ffff);

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         batch = $urandom_range(80, 220);
         if (RANDOM_ITEMS - random_count < batch + 80) begin
            batch = RANDOM_ITEMS - random_count;
         end
         settle_unit();
         idle_on = (random_count + batch >= RANDOM_ITEMS) ? 1'b0 : ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0: write_csr(SEED_ADDR, 32'h0000_0000);
            1: write_csr(SEED_ADDR, 32'hffff_ffff);
            2: write_csr(SEED_ADDR, 32'h7fff_fffe);
            3: write_csr(SEED_ADDR, 32'h0000_0001);
            4: write_csr(UNMAPPED_ADDR, $urandom);
            default: write_csr(SEED_ADDR, $urandom);
         endcase
         if ($urandom_range(0, 3) != 0) begin
            queue_req(mstdrr_pkg::ACTION_RESTART, $urandom, $urandom);
         end
         repeat (batch) queue_random_req();
         random_count += batch;
      end
      settle_unit();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mstdrr_pkg.sv
rtl/mstdrr_channels.sv
rtl/mstdrr_lehmer.sv
rtl/mstdrr_divider.sv
rtl/minstd_random_with_range_unit.sv
tb/tb_minstd_random_with_range_unit.sv
